FILE: rtl/soc_pkg.sv
package soc_pkg;

   localparam int SECTORS_IN_PAGE = 64;
   localparam int TABLE_SECTORS   = 65536;
   localparam int OWNER_BITS      = 16;

   localparam int PAGE_BITS   = 10;
   localparam int FIRST_BITS  = 6;
   localparam int COUNT_BITS  = 7;
   localparam int OWNER_IN_BITS = 16;

   localparam int TABLE_BITS = $clog2(TABLE_SECTORS);
   localparam int SECT_BITS  = $clog2(SECTORS_IN_PAGE + 1);
   localparam int END_BITS   = (SECT_BITS > 8) ? SECT_BITS : 8;
   localparam int PROD_BITS  = PAGE_BITS + SECT_BITS;
   localparam int FULL_BITS  = (PROD_BITS + 1 > TABLE_BITS) ? PROD_BITS + 1 : TABLE_BITS;

   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 8;

   typedef struct packed {
      logic                  en;
      logic                  we;
      logic [TABLE_BITS-1:0] addr;
      logic [OWNER_BITS-1:0] wdata;
   } ram_req_type;

endpackage

FILE: rtl/soc_owner_ram.sv
module soc_owner_ram (
   input  logic                           clock,
   input  soc_pkg::ram_req_type           ram_req,
   output logic [soc_pkg::OWNER_BITS-1:0] rd_data
);

   logic [soc_pkg::OWNER_BITS-1:0] mem [soc_pkg::TABLE_SECTORS];
   logic [soc_pkg::OWNER_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.en) begin
         if (ram_req.we) begin
            mem[ram_req.addr] <= ram_req.wdata;
         end else begin
            rd_data_ff <= mem[ram_req.addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sector_owner_check_and_set.sv
// an accepted word goes through ST_BASE (page base address), ST_WALK (one table access per
// sector of the clipped run, a check waiting for its last read) and ST_DONE (result out)
// throughput: one word at a time, set by the single table port walking one sector per cycle
// a new word is taken only back in ST_IDLE; ST_DONE holds while the result output is stalled
// after reset the table is swept to owner 0, one entry per cycle, no word taken until it ends
// reset clears control state only; result data registers are not reset
module sector_owner_check_and_set (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // page_number[9:0], first_sector[15:10], sector_count[22:16], owner_id[38:23], zero pad
   input  logic [soc_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // kind[0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // granted[0], run_clipped[1], zero pad
   output logic [soc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_BASE  = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic KIND_CHECK = 1'b0;
   localparam logic KIND_SET   = 1'b1;

   logic [2:0]                          state_ff, state_in;
   logic [soc_pkg::TABLE_BITS-1:0]      clr_addr_ff, clr_addr_in;
   logic                                kind_ff, kind_in;
   logic [soc_pkg::PAGE_BITS-1:0]       page_ff, page_in;
   logic [soc_pkg::END_BITS-1:0]        sector_ff, sector_in;
   logic [soc_pkg::END_BITS-1:0]        end_ff, end_in;
   logic [soc_pkg::OWNER_BITS-1:0]      owner_ff, owner_in;
   logic [soc_pkg::PROD_BITS-1:0]       base_ff, base_in;
   logic                                clipped_ff, clipped_in;
   logic                                granted_ff, granted_in;
   logic                                rd_pend_ff, rd_pend_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_granted_ff, rsp_granted_in;
   logic                                rsp_clipped_ff, rsp_clipped_in;

   logic [soc_pkg::PAGE_BITS-1:0]       req_page;
   logic [soc_pkg::FIRST_BITS-1:0]      req_first;
   logic [soc_pkg::COUNT_BITS-1:0]      req_count;
   logic [soc_pkg::OWNER_IN_BITS-1:0]   req_owner;
   logic [soc_pkg::END_BITS-1:0]        req_end;
   logic                                req_clip;
   logic [soc_pkg::FULL_BITS-1:0]       walk_sum;
   logic [soc_pkg::TABLE_BITS-1:0]      walk_addr;
   logic                                walk_more;
   logic                                rsp_free;
   soc_pkg::ram_req_type                ram_req;
   logic [soc_pkg::OWNER_BITS-1:0]      rd_data;

   soc_owner_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign req_page  = req_tdata[9:0];
   assign req_first = req_tdata[15:10];
   assign req_count = req_tdata[22:16];
   assign req_owner = req_tdata[38:23];
   assign req_end   = soc_pkg::END_BITS'(req_first) + soc_pkg::END_BITS'(req_count);
   assign req_clip  = req_end > soc_pkg::END_BITS'(soc_pkg::SECTORS_IN_PAGE);

   assign walk_sum  = soc_pkg::FULL_BITS'(base_ff) + soc_pkg::FULL_BITS'(sector_ff);
   assign walk_addr = walk_sum[soc_pkg::TABLE_BITS-1:0];
   assign walk_more = sector_ff < end_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(soc_pkg::RSP_DATA_BITS-2){1'b0}}, rsp_clipped_ff, rsp_granted_ff};

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      kind_in        = kind_ff;
      page_in        = page_ff;
      sector_in      = sector_ff;
      end_in         = end_ff;
      owner_in       = owner_ff;
      base_in        = base_ff;
      clipped_in     = clipped_ff;
      granted_in     = granted_ff;
      rd_pend_in     = 1'b0;
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_clipped_in = rsp_clipped_ff;
      ram_req.en     = 1'b0;
      ram_req.we     = 1'b0;
      ram_req.addr   = walk_addr;
      ram_req.wdata  = owner_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_req.en    = 1'b1;
            ram_req.we    = 1'b1;
            ram_req.addr  = clr_addr_ff;
            ram_req.wdata = '0;
            clr_addr_in   = clr_addr_ff + 1'b1;
            if (clr_addr_ff == soc_pkg::TABLE_BITS'(soc_pkg::TABLE_SECTORS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in    = req_tuser;
               page_in    = req_page;
               sector_in  = soc_pkg::END_BITS'(req_first);
               end_in     = req_clip ? soc_pkg::END_BITS'(soc_pkg::SECTORS_IN_PAGE) : req_end;
               owner_in   = soc_pkg::OWNER_BITS'(req_owner);
               clipped_in = req_clip;
               granted_in = 1'b1;
               state_in   = ST_BASE;
            end
         end
         ST_BASE: begin
            base_in  = soc_pkg::PROD_BITS'(page_ff)
                     * soc_pkg::PROD_BITS'(soc_pkg::SECTORS_IN_PAGE);
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (rd_pend_ff && (rd_data != owner_ff)) begin
               granted_in = 1'b0;
            end
            if (walk_more) begin
               ram_req.en = 1'b1;
               ram_req.we = (kind_ff == KIND_SET);
               rd_pend_in = (kind_ff == KIND_CHECK);
               sector_in  = sector_ff + 1'b1;
            end else if (!rd_pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = granted_ff;
               rsp_clipped_in = clipped_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      page_ff        <= page_in;
      sector_ff      <= sector_in;
      end_ff         <= end_in;
      owner_ff       <= owner_in;
      base_ff        <= base_in;
      clipped_ff     <= clipped_in;
      granted_ff     <= granted_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_clipped_ff <= rsp_clipped_in;
   end

endmodule

FILE: tb/sector_owner_tb_pkg.sv
`timescale 1ns / 1ps

package sector_owner_tb_pkg;

   typedef enum logic {
      RUN_CHECK = 1'b0,
      RUN_SET   = 1'b1
   } run_kind_e;

endpackage

FILE: tb/sector_owner_check_and_set_checker.sv
`timescale 1ns / 1ps

module sector_owner_check_and_set_checker
   import soc_pkg::*;
   import sector_owner_tb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   // page_number[9:0], first_sector[15:10], sector_count[22:16], owner_id[38:23], zero pad
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // kind[0]
   input  logic                     req_tuser,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // granted[0], run_clipped[1], zero pad
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output int                       pending_count,
   output int                       mismatch_count
);

   typedef struct packed {
      logic granted;
      logic run_clipped;
   } owner_verdict_t;

   logic [OWNER_BITS-1:0] owner_table [TABLE_SECTORS];
   owner_verdict_t        expected_verdicts [$];
   int                    results_seen;

   // walks the clipped run, checking or writing the shadow table
   function automatic owner_verdict_t walk_owner_run(
      input run_kind_e                kind,
      input logic [PAGE_BITS-1:0]     page,
      input logic [FIRST_BITS-1:0]    first,
      input logic [COUNT_BITS-1:0]    count,
      input logic [OWNER_IN_BITS-1:0] owner_in
   );
      owner_verdict_t        verdict;
      logic [OWNER_BITS-1:0] owner;
      int                    stop;
      int                    slot;
      verdict.granted     = 1'b1;
      verdict.run_clipped = 1'b0;
      owner = owner_in[OWNER_BITS-1:0];
      stop  = int'(first) + int'(count);
      if (stop > SECTORS_IN_PAGE) begin
         verdict.run_clipped = 1'b1;
         stop = SECTORS_IN_PAGE;
      end
      for (int s = int'(first); s < stop; s++) begin
         slot = (int'(page) * SECTORS_IN_PAGE + s) % TABLE_SECTORS;
         if (kind == RUN_CHECK) begin
            if (owner_table[slot] != owner) verdict.granted = 1'b0;
         end else begin
            owner_table[slot] = owner;
         end
      end
      return verdict;
   endfunction

   task automatic flag_mismatch(input string detail);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: result word %0d: %s", $realtime, results_seen, detail);
   endtask

   always @(posedge clock) begin
      owner_verdict_t want;
      owner_verdict_t got;
      if (reset) begin
         for (int i = 0; i < TABLE_SECTORS; i++) owner_table[i] = '0;
         expected_verdicts.delete();
         results_seen   = 0;
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.granted     = rsp_tdata[0];
            got.run_clipped = rsp_tdata[1];
            if (expected_verdicts.size() == 0) begin
               flag_mismatch($sformatf("unexpected word, granted=%b run_clipped=%b",
                                       got.granted, got.run_clipped));
            end else begin
               want = expected_verdicts.pop_front();
               if (got.granted !== want.granted || got.run_clipped !== want.run_clipped) begin
                  flag_mismatch($sformatf(
                     "expected granted=%b run_clipped=%b, got granted=%b run_clipped=%b",
                     want.granted, want.run_clipped, got.granted, got.run_clipped));
               end
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            expected_verdicts.push_back(walk_owner_run(run_kind_e'(req_tuser),
                                                       req_tdata[9:0], req_tdata[15:10],
                                                       req_tdata[22:16], req_tdata[38:23]));
         end
      end
      pending_count = expected_verdicts.size();
   end

endmodule

FILE: tb/tb_sector_owner_check_and_set.sv
`timescale 1ns / 1ps

module tb_sector_owner_check_and_set;
   import soc_pkg::*;
   import sector_owner_tb_pkg::*;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     req_tuser  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   int pending_count;
   int mismatch_count;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   bit hold_request       = 1'b0;
   int items_sent         = 0;

   int                     hot_pages [8];
   logic [OWNER_BITS-1:0]  recent_owners [4];

   sector_owner_check_and_set i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sector_owner_check_and_set_checker i_owner_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .pending_count  (pending_count),
      .mismatch_count (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      bit hold_served;
      hold_served = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            rsp_tready <= 1'b0;
            for (int i = 1; i < 400; i++) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // returns at a falling edge with the accepted word still on the bus
   task automatic send_word(input run_kind_e kind, input int page, input int first,
                            input int count, input int owner);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, owner[OWNER_IN_BITS-1:0], count[COUNT_BITS-1:0],
                     first[FIRST_BITS-1:0], page[PAGE_BITS-1:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   function automatic int pick_page();
      if ($urandom_range(99) < 80) return hot_pages[$urandom_range(7)];
      return $urandom_range(1023);
   endfunction

   function automatic int pick_count();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return 0;
      if (roll < 15) return $urandom_range(127, 65);
      return $urandom_range(64, 1);
   endfunction

   task automatic send_random_sequence();
      int roll, page, first, count, owner, run_end, sub_first, sub_count;
      roll  = $urandom_range(99);
      page  = pick_page();
      first = $urandom_range(63);
      count = pick_count();
      if (roll < 45) begin
         // set a run, then check a piece of it
         if (count == 0) count = 1;
         owner   = $urandom_range(16'hffff);
         recent_owners[$urandom_range(3)] = owner[OWNER_BITS-1:0];
         send_word(RUN_SET, page, first, count, owner);
         run_end   = (first + count > SECTORS_IN_PAGE) ? SECTORS_IN_PAGE : first + count;
         sub_first = $urandom_range(run_end - 1, first);
         sub_count = $urandom_range(run_end - sub_first, 1);
         if ($urandom_range(9) == 0) owner = owner ^ (1 << $urandom_range(15));
         send_word(RUN_CHECK, page, sub_first, sub_count, owner);
      end else if (roll < 75) begin
         owner = ($urandom_range(9) == 0) ? 0 : int'(recent_owners[$urandom_range(3)]);
         send_word(RUN_CHECK, page, first, count, owner);
      end else begin
         send_word(run_kind_e'($urandom_range(1)), $urandom_range(1023), first,
                   $urandom_range(127), $urandom_range(16'hffff));
      end
   endtask

   initial begin
      int sender_pcts [4];
      int receiver_pcts [4];
      int phase_start;
      sender_pcts   = '{0, 68, 0, 13};
      receiver_pcts = '{0, 0, 68, 13};
      hot_pages[0] = 0;
      hot_pages[1] = 1023;
      for (int i = 2; i < 8; i++) hot_pages[i] = $urandom_range(1023);
      for (int i = 0; i < 4; i++) recent_owners[i] = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty runs, page edges, clipping, owner extremes
      send_word(RUN_CHECK, 0, 0, 0, 0);
      send_word(RUN_CHECK, 0, 0, 64, 0);
      send_word(RUN_CHECK, 1023, 63, 1, 0);
      send_word(RUN_SET, 1023, 0, 64, 16'hffff);
      send_word(RUN_CHECK, 1023, 0, 64, 16'hffff);
      send_word(RUN_CHECK, 1023, 63, 127, 16'hffff);
      send_word(RUN_CHECK, 1023, 0, 64, 16'hfffe);
      send_word(RUN_SET, 5, 10, 127, 16'ha5a5);
      send_word(RUN_CHECK, 5, 10, 54, 16'ha5a5);
      send_word(RUN_CHECK, 5, 9, 2, 16'ha5a5);
      send_word(RUN_SET, 5, 63, 0, 16'h0001);
      send_word(RUN_CHECK, 5, 63, 1, 16'ha5a5);
      send_word(RUN_CHECK, 5, 0, 0, 16'h1234);
      send_word(RUN_CHECK, 1022, 32, 32, 0);
      send_word(RUN_CHECK, 1022, 32, 33, 0);
      send_word(RUN_SET, 0, 0, 1, 16'h5a5a);
      send_word(RUN_CHECK, 0, 0, 1, 16'h5a5b);
      send_word(RUN_CHECK, 0, 0, 1, 16'h5a5a);
      send_word(RUN_SET, 512, 21, 42, 16'h8001);
      send_word(RUN_CHECK, 512, 21, 42, 16'h8001);
      send_word(RUN_CHECK, 512, 20, 44, 16'h8001);
      send_word(RUN_SET, 512, 0, 64, 0);
      send_word(RUN_CHECK, 512, 0, 127, 0);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = sender_pcts[phase];
         receiver_stall_pct = receiver_pcts[phase];
         phase_start = items_sent;
         while (items_sent - phase_start < 500) begin
            if (phase == 0 && items_sent - phase_start >= 100) hold_request = 1'b1;
            send_random_sequence();
         end
         drain_results();
      end

      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
